// File: sv/entity_unescape_filter_core_defines.svh
// ----------------------------------------------------------------------------
// Entity unescape filter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ENTITY_UNESCAPE_FILTER_CORE_DEFINES_SVH
`define ENTITY_UNESCAPE_FILTER_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define EUF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define EUF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/euf_pkg.sv
// ----------------------------------------------------------------------------
// Entity unescape filter package
// Constants, entity tables, shared types and character helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package euf_pkg;

  localparam int HOLD_DEPTH = 5;
  localparam int MAX_DIGITS = 3;
  localparam int OUT_DEPTH  = HOLD_DEPTH + 1;
  localparam int NUM_ENT    = 5;
  localparam int HC_W       = $clog2(HOLD_DEPTH + 1);
  localparam int CNT_W      = $clog2(OUT_DEPTH + 1);

  typedef logic [7:0] byte_t;

  localparam byte_t CH_AMP   = 8'h26;
  localparam byte_t CH_HASH  = 8'h23;
  localparam byte_t CH_SEMI  = 8'h3B;
  localparam byte_t CH_TAB   = 8'h09;
  localparam byte_t CH_SPACE = 8'h20;
  localparam byte_t CH_NONE  = 8'h00;

  // Entity names after the ampersand, lower case, padded with zero bytes.
  localparam byte_t ENT_NAME [NUM_ENT][HOLD_DEPTH] = '{
    '{"l", "t", ";", CH_NONE, CH_NONE},
    '{"g", "t", ";", CH_NONE, CH_NONE},
    '{"a", "m", "p", ";", CH_NONE},
    '{"q", "u", "o", "t", ";"},
    '{"a", "p", "o", "s", ";"}
  };
  localparam logic [HC_W-1:0] ENT_LEN [NUM_ENT] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5};
  localparam byte_t ENT_CHAR [NUM_ENT] = '{8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27};

  typedef enum logic [1:0] {
    CLS_MISMATCH = 2'd0,
    CLS_EXTEND   = 2'd1,
    CLS_COMPLETE = 2'd2
  } cls_t;

  // Result list produced by one input transaction.
  typedef struct packed {
    logic [OUT_DEPTH-1:0][7:0] bytes;
    logic [CNT_W-1:0]          cnt;
    logic                      last;
  } euf_list_t;

  function automatic byte_t lower_ascii(input byte_t c);
    byte_t r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic is_digit(input byte_t c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

// File: sv/euf_hold.sv
// ----------------------------------------------------------------------------
// Entity unescape filter hold state
// Holds the bytes of a candidate entity, classifies each new byte and builds
// the list of result bytes that the transaction releases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "entity_unescape_filter_core_defines.svh"

module euf_hold
  import euf_pkg::*;
#(
  parameter int DIGITS_MAX = MAX_DIGITS
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  byte_t     char_in,
  input  logic      last_in,
  output euf_list_t list
);

  byte_t            held_r   [HOLD_DEPTH];
  byte_t            held_nxt [HOLD_DEPTH];
  logic [HC_W-1:0]  hc_r, hc_nxt;
  logic [9:0]       nv_r, nv_nxt;

  cls_t             cls;
  byte_t            val;
  logic             num_mode;
  logic [HC_W-1:0]  digits;
  logic [HC_W-1:0]  p;
  logic             found;
  logic             ok;
  logic [13:0]      nv_acc;
  logic [HC_W-1:0]  m;
  byte_t            tail;
  logic             tail_v;

  // Classification of the new byte against the current hold.
  always_comb begin
    cls      = CLS_MISMATCH;
    val      = CH_NONE;
    found    = 1'b0;
    ok       = 1'b0;
    num_mode = (hc_r >= HC_W'(2)) && (held_r[1] == CH_HASH);
    digits   = hc_r - HC_W'(2);
    p        = hc_r - HC_W'(1);
    if (hc_r != '0) begin
      if (hc_r == HC_W'(1) && char_in == CH_HASH) begin
        cls = CLS_EXTEND;
      end else if (num_mode) begin
        if (is_digit(char_in) && digits < HC_W'(DIGITS_MAX)) begin
          cls = CLS_EXTEND;
        end else if (char_in == CH_SEMI && digits >= HC_W'(1) && nv_r != '0) begin
          cls = CLS_COMPLETE;
          val = nv_r[7:0];
        end
      end else begin
        for (int k = 0; k < NUM_ENT; k++) begin
          ok = (p < ENT_LEN[k]) && (lower_ascii(char_in) == ENT_NAME[k][p]);
          for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
            if (HC_W'(i) < p && lower_ascii(held_r[i+1]) != ENT_NAME[k][i]) begin
              ok = 1'b0;
            end
          end
          if (ok && !found) begin
            found = 1'b1;
            cls   = (p + HC_W'(1) == ENT_LEN[k]) ? CLS_COMPLETE : CLS_EXTEND;
            val   = ENT_CHAR[k];
          end
        end
      end
      if (cls == CLS_EXTEND && hc_r >= HC_W'(HOLD_DEPTH)) begin
        cls = CLS_MISMATCH;
      end
    end
  end

  // Next state and the result list: a prefix of the hold plus at most one tail byte.
  always_comb begin
    held_nxt = held_r;
    hc_nxt   = '0;
    nv_nxt   = '0;
    m        = '0;
    tail     = char_in;
    tail_v   = 1'b0;
    nv_acc   = ({4'b0, nv_r} << 3) + ({4'b0, nv_r} << 1) + {10'b0, char_in[3:0]};
    case (cls)
      CLS_COMPLETE: begin
        tail   = val;
        tail_v = 1'b1;
      end
      CLS_EXTEND: begin
        for (int i = 0; i < HOLD_DEPTH; i++) begin
          if (hc_r == HC_W'(i)) begin
            held_nxt[i] = char_in;
          end
        end
        if (last_in) begin
          m      = hc_r;
          tail_v = 1'b1;
        end else begin
          hc_nxt = hc_r + HC_W'(1);
          nv_nxt = (num_mode && is_digit(char_in)) ? nv_acc[9:0] : nv_r;
        end
      end
      default: begin
        m      = hc_r;
        tail   = (char_in == CH_TAB) ? CH_SPACE : char_in;
        tail_v = !(char_in == CH_AMP && !last_in);
        if (char_in == CH_AMP && !last_in) begin
          held_nxt[0] = CH_AMP;
          hc_nxt      = HC_W'(1);
        end
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      list.bytes[i] = (HC_W'(i) < m) ? held_r[i] : tail;
    end
    list.bytes[OUT_DEPTH-1] = tail;
    list.cnt  = CNT_W'(m) + CNT_W'(tail_v);
    list.last = last_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r <= '0;
      nv_r <= '0;
    end else if (load) begin
      hc_r <= hc_nxt;
      nv_r <= nv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_r <= held_nxt;
    end
  end

  `EUF_ASSERT_NOW(a_hold_bound, 1'b1, hc_r <= HC_W'(HOLD_DEPTH), "hold count above depth")
  `EUF_ASSERT_NEXT(a_last_clears, load && last_in, hc_r == '0 && nv_r == '0, "hold not cleared")

endmodule

// File: sv/euf_emit_buf.sv
// ----------------------------------------------------------------------------
// Entity unescape filter result buffer
// Registers the result list of a transaction and shifts it out one byte per
// accepted output transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "entity_unescape_filter_core_defines.svh"

module euf_emit_buf
  import euf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  euf_list_t list,
  output logic      take_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output byte_t     out_char,
  output logic      out_last
);

  logic [OUT_DEPTH-1:0][7:0] buf_r, buf_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      last_r, last_nxt;

  assign out_valid  = (cnt_r != '0);
  assign out_char   = buf_r[0];
  assign out_last   = last_r && (cnt_r == CNT_W'(1));
  assign take_ready = (cnt_r == '0) || (cnt_r == CNT_W'(1) && out_ready);

  always_comb begin
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    last_nxt = last_r;
    if (load) begin
      buf_nxt  = list.bytes;
      cnt_nxt  = list.cnt;
      last_nxt = list.last;
    end else if (out_valid && out_ready) begin
      for (int i = 0; i < OUT_DEPTH - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      last_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  `EUF_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(OUT_DEPTH), "result count above depth")
  `EUF_ASSERT_NOW(a_last_nonempty, load && list.last, list.cnt != '0, "end of piece with no result")
  `EUF_ASSERT_NEXT(a_load_count, load, cnt_r == $past(list.cnt), "result count not loaded")

endmodule

// File: sv/entity_unescape_filter_core.sv
// ----------------------------------------------------------------------------
// Entity unescape filter core
// Streaming text filter that decodes HTML character entities byte by byte.
// ----------------------------------------------------------------------------
// Usage: text bytes enter on the in_ channel (in_valid / in_ready), with
// in_last_in marking the final byte of a text piece. Filtered bytes leave on
// the out_ channel (out_valid / out_ready), with out_last_out on the final
// byte of the piece. A tab becomes a space. Named entities (lt, gt, amp, quot,
// apos, any letter case) and numeric entities of one to three decimal digits
// are replaced by their character; anything that stops matching is released
// verbatim. A transaction can yield no result (a byte held as part of a
// candidate entity) or up to six bytes (a full hold flushed plus the new byte).
// Output: results of an accepted transaction are registered and appear in
// the next cycle. Throughput: one transaction per cycle while each yields at
// most one result and out_ready is high; a longer list holds off the next
// transaction while the buffer drains one byte per cycle with out_ready high.
// Stall: while the receiver holds out_ready low, the result register keeps
// its byte and in_ready stays low as long as any result byte is waiting.
// Reset: synchronous, active low rst_n; the hold and result buffer are empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module entity_unescape_filter_core
  import euf_pkg::*;
#(
  parameter int DIGITS_MAX = MAX_DIGITS
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  input  logic       in_last_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char_out,
  output logic       out_last_out
);

  euf_list_t list;
  logic      load;

  // A transaction is taken when the result buffer is empty or its last byte
  // leaves in this same cycle.
  assign load = in_valid && in_ready;

  // Entity hold: tracks the candidate entity and forms the result list.
  euf_hold #(
    .DIGITS_MAX (DIGITS_MAX)
  ) u_hold (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .char_in (in_char_in),
    .last_in (in_last_in),
    .list    (list)
  );

  // Result buffer: registers the list, draining a byte per cycle on out_ready.
  euf_emit_buf u_emit_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .list       (list),
    .take_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char_out),
    .out_last   (out_last_out)
  );

endmodule
